// File: hdl/rsct_pkg.sv
// shared types, codes and helpers for the rotary-set countdown timer
`timescale 1ns / 1ps

package rsct_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_HOLD_TICKS     = 2'd0,
    REG_TICKS_PER_SEC  = 2'd1,
    REG_COLON_OFF_TICK = 2'd2,
    REG_MAX_MINUTES    = 2'd3
  } cfg_reg_t;

  // display update codes
  typedef enum logic [1:0] {
    UPD_NONE      = 2'd0,
    UPD_SHOW      = 2'd1,
    UPD_COLON_OFF = 2'd2
  } upd_t;

  localparam logic [15:0] HOLD_TICKS_RST     = 16'd200;
  localparam logic [15:0] TICKS_PER_SEC_RST  = 16'd1000;
  localparam logic [15:0] COLON_OFF_TICK_RST = 16'd500;
  localparam logic [6:0]  MAX_MINUTES_RST    = 7'd9;
  localparam logic [6:0]  MINUTES_LIMIT      = 7'd99;
  localparam logic [5:0]  SECONDS_TOP        = 6'd59;

  typedef struct packed {
    logic [7:0]  hold_ticks;
    logic [15:0] ticks_per_sec;
    logic [15:0] colon_off_tick;
    logic [6:0]  max_minutes;
  } cfg_t;

  typedef struct packed {
    logic        adjust_mode;
    logic [7:0]  hold_count;
    logic [15:0] tick_count;
    logic [6:0]  minutes;
    logic [5:0]  seconds;
    logic        clock_latch;
    logic        alarm_flag;
    logic        colon_lit;
  } state_t;

  // split 0..127 into tens and ones, tens by reciprocal multiply
  function automatic logic [7:0] bin2bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [7:0]  tens_x10;
    logic [7:0]  ones;
    prod     = 15'({8'd0, v} * 15'd205);
    tens     = prod[14:11];
    tens_x10 = 8'({4'd0, tens} * 8'd10);
    ones     = {1'b0, v} - tens_x10;
    return {tens, ones[3:0]};
  endfunction

endpackage

// File: hdl/rsct_step.sv
// next-state logic for one millisecond tick of the countdown timer
`timescale 1ns / 1ps

module rsct_step (
  input  rsct_pkg::state_t cur,
  input  rsct_pkg::cfg_t   cfg,
  input  logic             button_pressed,
  input  logic             enc_clock,
  input  logic             enc_data,
  output rsct_pkg::state_t nxt,
  output rsct_pkg::upd_t   code
);
  import rsct_pkg::*;

  logic [8:0]  hold_inc;
  logic [16:0] tick_inc;
  logic [6:0]  cap;
  state_t      s;
  upd_t        c;
  logic        at_zero;

  assign hold_inc = {1'b0, cur.hold_count} + 9'd1;
  assign cap      = (cfg.max_minutes > MINUTES_LIMIT) ? MINUTES_LIMIT : cfg.max_minutes;

  always_comb begin
    s = cur;
    c = UPD_NONE;
    tick_inc = 17'd0;
    // button hold toggles the mode
    if (button_pressed) begin
      if (hold_inc >= {1'b0, cfg.hold_ticks}) begin
        s.hold_count = '0;
        s.tick_count = '0;
        if (cur.adjust_mode) begin
          s.adjust_mode = 1'b0;
          s.alarm_flag  = 1'b0;
        end else begin
          s.adjust_mode = 1'b1;
        end
      end else begin
        s.hold_count = hold_inc[7:0];
      end
    end else begin
      s.hold_count = '0;
    end

    at_zero = (s.seconds == 6'd0) && (s.minutes == 7'd0);

    if (!s.adjust_mode) begin
      tick_inc = {1'b0, s.tick_count} + 17'd1;
      if (tick_inc >= {1'b0, cfg.ticks_per_sec}) begin
        s.tick_count = '0;
        if (at_zero) begin
          s.alarm_flag = 1'b1;
        end else if (s.seconds != 6'd0) begin
          s.seconds = s.seconds - 6'd1;
        end else begin
          s.minutes = s.minutes - 7'd1;
          s.seconds = SECONDS_TOP;
        end
        s.colon_lit = 1'b1;
        c = UPD_SHOW;
      end else begin
        s.tick_count = tick_inc[15:0];
      end
      if (s.tick_count == cfg.colon_off_tick) begin
        s.colon_lit = 1'b0;
        c = UPD_COLON_OFF;
      end
    end else if (enc_clock != s.clock_latch) begin
      s.clock_latch = enc_clock;
      if (enc_clock ^ enc_data) begin
        // step up, minutes capped
        if (s.seconds >= SECONDS_TOP) begin
          if (s.minutes < cap) begin
            s.minutes = s.minutes + 7'd1;
            s.seconds = '0;
          end
        end else begin
          s.seconds = s.seconds + 6'd1;
        end
      end else if (s.seconds != 6'd0) begin
        s.seconds = s.seconds - 6'd1;
      end else if (s.minutes != 7'd0) begin
        s.minutes = s.minutes - 7'd1;
        s.seconds = SECONDS_TOP;
      end
      s.colon_lit = 1'b1;
      c = UPD_SHOW;
    end
  end

  assign nxt  = s;
  assign code = c;

endmodule

// File: hdl/rotary_set_countdown_timer_top.sv
// top level of the rotary-set minutes:seconds countdown timer
`timescale 1ns / 1ps

// One input transfer is one millisecond tick carrying the button level and
// the two encoder pins. Every tick is handled combinationally: the
// timer state registers feed the step logic, and the new state and the
// display result are written together on the accepting edge, so one tick
// can be taken every cycle while the result slot is not stalled.
// The result register doubles as the output stage; a new tick is accepted
// whenever the result slot is empty or is being taken in the same cycle.
// Holding the button for hold_ticks ticks toggles adjust and run mode; in
// adjust mode encoder clock edges step the time, in run mode the time counts
// down once per ticks_per_second ticks and the alarm sets at 0:00.
// Configuration writes are always accepted and take effect on the next tick.

module rotary_set_countdown_timer_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  // tick input: button_pressed[0], enc_clock[1], enc_data[2], zero [7:3]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // result: min_tens[3:0], min_ones[7:4], sec_tens[10:8], sec_ones[14:11],
  // colon_on[15], alarm[16], adjusting[17], zero [23:18]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  // result kind: display_update[1:0]
  output logic [1:0]  out_tuser
);
  import rsct_pkg::*;

  cfg_t        cfg_r;
  state_t      state_r;
  state_t      state_nxt;
  upd_t        code_nxt;
  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic [1:0]  out_user_r;
  logic        in_xfer;
  logic [7:0]  min_bcd;
  logic [7:0]  sec_bcd;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_ticks     <= HOLD_TICKS_RST[7:0];
      cfg_r.ticks_per_sec  <= TICKS_PER_SEC_RST;
      cfg_r.colon_off_tick <= COLON_OFF_TICK_RST;
      cfg_r.max_minutes    <= MAX_MINUTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_addr))
        REG_HOLD_TICKS:     cfg_r.hold_ticks     <= cfg_data[7:0];
        REG_TICKS_PER_SEC:  cfg_r.ticks_per_sec  <= cfg_data;
        REG_COLON_OFF_TICK: cfg_r.colon_off_tick <= cfg_data;
        REG_MAX_MINUTES:    cfg_r.max_minutes    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // per-tick state update
  rsct_step u_step (
    .cur            (state_r),
    .cfg            (cfg_r),
    .button_pressed (in_tdata[0]),
    .enc_clock      (in_tdata[1]),
    .enc_data       (in_tdata[2]),
    .nxt            (state_nxt),
    .code           (code_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.adjust_mode <= 1'b1;
      state_r.hold_count  <= '0;
      state_r.tick_count  <= '0;
      state_r.minutes     <= '0;
      state_r.seconds     <= '0;
      state_r.clock_latch <= 1'b0;
      state_r.alarm_flag  <= 1'b0;
      state_r.colon_lit   <= 1'b0;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  // digit split of the new time
  assign min_bcd = bin2bcd(state_nxt.minutes);
  assign sec_bcd = bin2bcd({1'b0, state_nxt.seconds});

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= {6'd0, state_nxt.adjust_mode, state_nxt.alarm_flag,
                     state_nxt.colon_lit, sec_bcd[3:0], sec_bcd[6:4],
                     min_bcd[3:0], min_bcd[7:4]};
      out_user_r <= code_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // time never leaves its legal range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.seconds <= SECONDS_TOP) && (state_r.minutes <= MINUTES_LIMIT))
    else $error("timer state out of range");

  // digits shown are valid BCD
  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:0] <= 4'd9) && (out_tdata[7:4] <= 4'd9) &&
                   (out_tdata[10:8] <= 3'd5) && (out_tdata[14:11] <= 4'd9))
    else $error("result digit not BCD");

  // no update code in adjust mode other than show or none
  a_adjust_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[17]) |-> (out_tuser != UPD_COLON_OFF))
    else $error("colon-off refresh in adjust mode");

  // every accepted tick yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_tvalid)
    else $error("accepted tick produced no result");

endmodule

// File: bench/tb_rotary_set_countdown_timer_top.sv
// self-checking bench for the rotary-set countdown timer: directed ticks, then random phases
`timescale 1ns / 1ps

module tb_rotary_set_countdown_timer_top;
  import rsct_pkg::*;

  localparam int PHASES    = 10;
  localparam int PER_PHASE = 93;

  // one display result as the bench sees it
  typedef struct packed {
    logic [3:0] min_tens;
    logic [3:0] min_ones;
    logic [2:0] sec_tens;
    logic [3:0] sec_ones;
    logic       colon_on;
    logic       alarm;
    logic       adjusting;
    upd_t       upd;
  } disp_t;

  // one line of the directed script: a register write or a tick
  typedef struct {
    bit          is_cfg;
    cfg_reg_t    reg_idx;
    logic [15:0] reg_val;
    logic        btn;
    logic        ec;
    logic        ed;
    bit          chk;
    disp_t       want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  rotary_set_countdown_timer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),     // button_pressed, enc_clock, enc_data, zero pad
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),    // min_tens, min_ones, sec_tens, sec_ones, colon, alarm, adj
    .out_tuser (out_tuser)     // display_update
  );

  always #4 clk = ~clk;

  // bench copy of the timer registers and settings
  cfg_t        cur_cfg;
  logic        t_adjust;
  logic [7:0]  t_hold;
  logic [15:0] t_ticks;
  logic [6:0]  t_mins;
  logic [5:0]  t_secs;
  logic        t_latch;
  logic        t_alarm;
  logic        t_colon;

  disp_t     disp_due[$];
  plan_row_t script[$];
  int        mismatches = 0;
  bit        quiet = 1'b0;
  int        stall_left = 0;
  logic      enc_lvl = 1'b0;

  string field_name [8] = '{"min_tens", "min_ones", "sec_tens", "sec_ones",
                            "colon_on", "alarm", "adjusting", "display_update"};

  // remove one second, stopping at 0:00
  function automatic void take_second();
    if (t_secs != 0) begin
      t_secs = t_secs - 6'd1;
    end else if (t_mins != 0) begin
      t_mins = t_mins - 7'd1;
      t_secs = SECONDS_TOP;
    end
  endfunction

  // advance the timer copy by one tick and return the display it shows
  function automatic disp_t advance_timer(input logic btn, input logic ec, input logic ed);
    disp_t d;
    upd_t  code;
    int    cap;
    code = UPD_NONE;
    cap = (cur_cfg.max_minutes > MINUTES_LIMIT) ? int'(MINUTES_LIMIT) : int'(cur_cfg.max_minutes);
    // button hold comes first, then the mode that results
    if (btn) begin
      if (int'(t_hold) + 1 >= int'(cur_cfg.hold_ticks)) begin
        t_hold  = '0;
        t_ticks = '0;
        if (t_adjust) begin
          t_adjust = 1'b0;
          t_alarm  = 1'b0;
        end else begin
          t_adjust = 1'b1;
        end
      end else begin
        t_hold = t_hold + 8'd1;
      end
    end else begin
      t_hold = '0;
    end
    if (!t_adjust) begin
      if (int'(t_ticks) + 1 >= int'(cur_cfg.ticks_per_sec)) begin
        t_ticks = '0;
        if (t_secs == 0 && t_mins == 0) t_alarm = 1'b1;
        else take_second();
        t_colon = 1'b1;
        code    = UPD_SHOW;
      end else begin
        t_ticks = t_ticks + 16'd1;
      end
      // colon-off refresh wins over a second elapsing in the same tick
      if (t_ticks == cur_cfg.colon_off_tick) begin
        t_colon = 1'b0;
        code    = UPD_COLON_OFF;
      end
    end else if (ec != t_latch) begin
      t_latch = ec;
      if (ec ^ ed) begin
        if (t_secs >= SECONDS_TOP) begin
          if (int'(t_mins) < cap) begin
            t_mins = t_mins + 7'd1;
            t_secs = '0;
          end
        end else begin
          t_secs = t_secs + 6'd1;
        end
      end else begin
        take_second();
      end
      t_colon = 1'b1;
      code    = UPD_SHOW;
    end
    d.min_tens  = 4'(t_mins / 7'd10);
    d.min_ones  = 4'(t_mins % 7'd10);
    d.sec_tens  = 3'(t_secs / 6'd10);
    d.sec_ones  = 4'(t_secs % 6'd10);
    d.colon_on  = t_colon;
    d.alarm     = t_alarm;
    d.adjusting = t_adjust;
    d.upd       = code;
    return d;
  endfunction

  function automatic logic [3:0] field_of(input disp_t d, input int k);
    case (k)
      0:       return d.min_tens;
      1:       return d.min_ones;
      2:       return {1'b0, d.sec_tens};
      3:       return d.sec_ones;
      4:       return {3'b0, d.colon_on};
      5:       return {3'b0, d.alarm};
      6:       return {3'b0, d.adjusting};
      default: return {2'b0, d.upd};
    endcase
  endfunction

  function automatic plan_row_t tick_row(input logic b, input logic c, input logic d,
                                         input bit chk = 1'b0, input disp_t want = '0);
    plan_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = REG_HOLD_TICKS;
    r.reg_val = '0;
    r.btn     = b;
    r.ec      = c;
    r.ed      = d;
    r.chk     = chk;
    r.want    = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input cfg_reg_t idx, input logic [15:0] val);
    plan_row_t r;
    r = tick_row(1'b0, 1'b0, 1'b0);
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // one tick transfer, with an occasional idle burst ahead of it
  task automatic send_tick(input logic btn, input logic ec, input logic ed,
                           input bit typed = 1'b0, input disp_t want = '0);
    disp_t pred;
    int    gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, ed, ec, btn};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    pred = advance_timer(btn, ec, ed);
    disp_due.push_back(typed ? want : pred);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_HOLD_TICKS:     cur_cfg.hold_ticks     = val[7:0];
      REG_TICKS_PER_SEC:  cur_cfg.ticks_per_sec  = val;
      REG_COLON_OFF_TICK: cur_cfg.colon_off_tick = val;
      REG_MAX_MINUTES:    cur_cfg.max_minutes    = val[6:0];
      default: ;
    endcase
  endtask

  // stop ticks and let every pending display come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (disp_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // one stretch of random stimulus: a knob turn, a button hold, a quiet spell or noise
  task automatic run_action(input int up_pct, inout int sent);
    int   kind;
    int   n;
    int   len;
    int   lim;
    logic up;
    logic b;
    logic c;
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      n  = $urandom_range(1, 30);
      up = ($urandom_range(0, 99) < up_pct);
      repeat (n) begin
        enc_lvl = ~enc_lvl;
        send_tick(1'b0, enc_lvl, up ? ~enc_lvl : enc_lvl);
        sent++;
        // dwell on a detent now and then; data alone never steps
        if ($urandom_range(0, 3) == 0) begin
          send_tick(1'b0, enc_lvl, 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end else if (kind <= 5) begin
      len = (cur_cfg.hold_ticks == 0) ? 1 : int'(cur_cfg.hold_ticks);
      case ($urandom_range(0, 4))
        0:       len = len - 1;                       // released one tick early
        1:       len = len + $urandom_range(1, 3);    // held past the toggle
        default: ;
      endcase
      repeat (len) send_tick(1'b1, enc_lvl, 1'($urandom_range(0, 1)));
      send_tick(1'b0, enc_lvl, 1'($urandom_range(0, 1)));
      sent += len + 1;
    end else if (kind <= 7) begin
      lim = 3 * int'(cur_cfg.ticks_per_sec);
      if (lim < 1 || lim > 40) lim = 40;
      n = $urandom_range(1, lim);
      repeat (n) send_tick(1'b0, enc_lvl, 1'($urandom_range(0, 1)));
      sent += n;
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        b = 1'($urandom_range(0, 1));
        c = 1'($urandom_range(0, 1));
        send_tick(b, c, 1'($urandom_range(0, 1)));
        enc_lvl = c;
      end
      sent += n;
    end
  endtask

  // receiver side: random stall bursts, none near the end
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // every result transfer is matched against the oldest pending display
  always @(posedge clk) begin : check_results
    disp_t want;
    disp_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.min_tens  = out_tdata[3:0];
      got.min_ones  = out_tdata[7:4];
      got.sec_tens  = out_tdata[10:8];
      got.sec_ones  = out_tdata[14:11];
      got.colon_on  = out_tdata[15];
      got.alarm     = out_tdata[16];
      got.adjusting = out_tdata[17];
      got.upd       = upd_t'(out_tuser);
      if (disp_due.size() == 0) begin
        $display("%0t: result with none pending, expected nothing, got %h/%h",
                 $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = disp_due.pop_front();
        for (int k = 0; k < 8; k++) begin
          if (field_of(got, k) !== field_of(want, k)) begin
            $display("%0t: %s expected %0d, got %0d", $time, field_name[k],
                     field_of(want, k), field_of(got, k));
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    int          i;
    int          sent;
    int          up_pct;
    logic [15:0] h;
    logic [15:0] t;
    logic [15:0] c;
    logic [15:0] m;

    cur_cfg.hold_ticks     = HOLD_TICKS_RST[7:0];
    cur_cfg.ticks_per_sec  = TICKS_PER_SEC_RST;
    cur_cfg.colon_off_tick = COLON_OFF_TICK_RST;
    cur_cfg.max_minutes    = MAX_MINUTES_RST;
    t_adjust = 1'b1;
    t_hold   = '0;
    t_ticks  = '0;
    t_mins   = '0;
    t_secs   = '0;
    t_latch  = 1'b0;
    t_alarm  = 1'b0;
    t_colon  = 1'b0;

    // defaults after reset: adjust mode at 0:00
    script.push_back(tick_row(0, 0, 0, 1, disp_t'{4'd0, 4'd0, 3'd0, 4'd0, 1'b0, 1'b0, 1'b1,
                                                   UPD_NONE}));
    script.push_back(tick_row(0, 1, 0, 1, disp_t'{4'd0, 4'd0, 3'd0, 4'd1, 1'b1, 1'b0, 1'b1,
                                                   UPD_SHOW}));
    script.push_back(tick_row(0, 0, 0, 1, disp_t'{4'd0, 4'd0, 3'd0, 4'd0, 1'b1, 1'b0, 1'b1,
                                                   UPD_SHOW}));
    // step down at 0:00 stays put
    script.push_back(tick_row(0, 1, 1, 1, disp_t'{4'd0, 4'd0, 3'd0, 4'd0, 1'b1, 1'b0, 1'b1,
                                                   UPD_SHOW}));
    script.push_back(tick_row(0, 1, 1, 1, disp_t'{4'd0, 4'd0, 3'd0, 4'd0, 1'b1, 1'b0, 1'b1,
                                                   UPD_NONE}));
    script.push_back(tick_row(0, 0, 1, 1, disp_t'{4'd0, 4'd0, 3'd0, 4'd1, 1'b1, 1'b0, 1'b1,
                                                   UPD_SHOW}));
    script.push_back(tick_row(1, 0, 1, 1, disp_t'{4'd0, 4'd0, 3'd0, 4'd1, 1'b1, 1'b0, 1'b1,
                                                   UPD_NONE}));
    script.push_back(tick_row(0, 0, 0));
    // zero hold time, one-tick seconds, colon-off never reached, oversized minute cap
    script.push_back(cfg_row(REG_HOLD_TICKS, 16'd0));
    script.push_back(cfg_row(REG_TICKS_PER_SEC, 16'd1));
    script.push_back(cfg_row(REG_COLON_OFF_TICK, 16'hFFFF));
    script.push_back(cfg_row(REG_MAX_MINUTES, 16'd127));
    script.push_back(tick_row(1, 0, 0));
    script.push_back(tick_row(0, 1, 0));    // alarm at 0:00, encoder ignored in run mode
    script.push_back(tick_row(1, 1, 0));    // back to adjust, latched clock differs
    script.push_back(tick_row(0, 1, 1));
    // zero-length second with colon-off on tick zero
    script.push_back(cfg_row(REG_TICKS_PER_SEC, 16'd0));
    script.push_back(cfg_row(REG_COLON_OFF_TICK, 16'd0));
    script.push_back(cfg_row(REG_HOLD_TICKS, 16'd1));
    script.push_back(tick_row(1, 0, 0));
    script.push_back(tick_row(0, 0, 0));
    script.push_back(tick_row(1, 1, 1));
    // top of every range, minute cap of zero
    script.push_back(cfg_row(REG_HOLD_TICKS, 16'd255));
    script.push_back(cfg_row(REG_TICKS_PER_SEC, 16'hFFFF));
    script.push_back(cfg_row(REG_COLON_OFF_TICK, 16'hFFFE));
    script.push_back(cfg_row(REG_MAX_MINUTES, 16'd0));
    script.push_back(tick_row(0, 0, 1));
    script.push_back(tick_row(0, 1, 1));
    script.push_back(tick_row(0, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    i = 0;
    while (i < script.size()) begin
      if (script[i].is_cfg) begin
        drain_results();
        while (i < script.size() && script[i].is_cfg) begin
          write_reg(script[i].reg_idx, script[i].reg_val);
          i++;
        end
        cfg_valid <= 1'b0;
      end else begin
        send_tick(script[i].btn, script[i].ec, script[i].ed, script[i].chk, script[i].want);
        enc_lvl = script[i].ec;
        i++;
      end
    end

    // random phases, each with its own settings; the last ones run without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin h = 16'd1;   t = 16'd2;     c = 16'd1;     m = 16'd0;   end
        1: begin h = 16'd3;   t = 16'd5;     c = 16'd2;     m = 16'd99;  end
        2: begin h = 16'd0;   t = 16'd1;     c = 16'hFFFF;  m = 16'd127; end
        3: begin h = 16'd255; t = 16'hFFFF;  c = 16'hFFFE;  m = 16'd99;  end
        default: begin
          h = 16'($urandom_range(1, 8));
          t = 16'($urandom_range(2, 12));
          c = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(1, t - 1));
          m = 16'($urandom_range(0, 127));
        end
      endcase
      up_pct = (ph == 1) ? 90 : 20 + 30 * $urandom_range(0, 2);
      quiet  = (ph >= PHASES - 2);
      drain_results();
      write_reg(REG_HOLD_TICKS, h);
      write_reg(REG_TICKS_PER_SEC, t);
      write_reg(REG_COLON_OFF_TICK, c);
      write_reg(REG_MAX_MINUTES, m);
      cfg_valid <= 1'b0;
      sent = 0;
      while (sent < PER_PHASE) run_action(up_pct, sent);
    end

    drain_results();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: rotary_set_countdown_timer_top.f
hdl/rsct_pkg.sv
hdl/rsct_step.sv
hdl/rotary_set_countdown_timer_top.sv
bench/tb_rotary_set_countdown_timer_top.sv
